/* rtl/dpb_pkg.sv */
// Shared types, codes and constants for the depth pixel back-projection block.
// No dependencies; every other file but dpb_checker imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

  localparam int DIM_BITS    = 16;
  localparam int STRIDE_BITS = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Millimetre decode: z = floor((mm * 8192 + 62) / 125) by reciprocal.
  localparam logic [30:0] MM_RECIP = 31'd1099511628;
  localparam int          MM_SHIFT = 37;
  localparam logic [29:0] MM_BIAS  = 30'd62;

  localparam int MAG_BITS = 34;
  localparam int K_BITS   = 64;
  localparam int ACC_BITS = MAG_BITS + K_BITS;
  localparam int RND_POS  = 47;
  localparam logic [5:0] MUL_STEPS = 6'(MAG_BITS);

  typedef enum logic [2:0] {
    CFG_STRIDE  = 3'd0,
    CFG_FORMAT  = 3'd1,
    CFG_MIN     = 3'd2,
    CFG_MAX     = 3'd3,
    CFG_CX      = 3'd4,
    CFG_CY      = 3'd5,
    CFG_IFX     = 3'd6,
    CFG_IFY     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FMT_MM_LE  = 2'd0,
    FMT_MM_BE  = 2'd1,
    FMT_F32_LE = 2'd2,
    FMT_F32_BE = 2'd3
  } fmt_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_BND,
    ST_MUL,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    logic [7:0]  stride;
    fmt_e        fmt;
    logic [31:0] depth_lo;
    logic [31:0] depth_hi;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] inv_fx;
    logic [31:0] inv_fy;
  } dpb_cfg_t;

  typedef struct packed {
    logic [31:0]         raw;
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] row;
    logic                sampled;
    logic                frame_end;
  } dpb_item_t;

  typedef struct packed {
    logic sampled;
    logic point_valid;
    logic frame_done;
  } dpb_flags_t;

endpackage

`default_nettype wire

/* rtl/dpb_queue.sv */
// Short queue of classified items between the front and back parts.
// Depends on dpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dpb_pkg::dpb_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output dpb_pkg::dpb_item_t item_o
);
  import dpb_pkg::*;

  dpb_item_t mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_BITS:0]   cnt_q, cnt_d;

  function automatic logic [QPTR_BITS-1:0] inc_ptr(logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? inc_ptr(wr_q) : wr_q;
    rd_d  = pop_i ? inc_ptr(rd_q) : rd_q;
    cnt_d = cnt_q + (QPTR_BITS+1)'(push_i) - (QPTR_BITS+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/dpb_front.sv */
// Front part: accepts pixels, tracks column and row phase, classifies items.
// Depends on dpb_pkg; feeds dpb_queue.
`timescale 1ns / 1ps
`default_nettype none

module dpb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         stride_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        raw_i,
  input  logic               row_end_i,
  input  logic               frame_end_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output dpb_pkg::dpb_item_t q_item_o
);
  import dpb_pkg::*;

  logic [DIM_BITS-1:0]    col_q, col_d, row_q, row_d;
  logic [STRIDE_BITS-1:0] cph_q, cph_d, rph_q, rph_d;
  logic [STRIDE_BITS:0]   stride_eff;
  logic                   accept, sampled;

  function automatic logic [STRIDE_BITS-1:0] next_phase(logic [STRIDE_BITS-1:0] ph,
                                                        logic [STRIDE_BITS:0] s);
    logic [STRIDE_BITS:0] n;
    n = {1'b0, ph} + 1'b1;
    return (n >= s) ? '0 : n[STRIDE_BITS-1:0];
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sampled    = (cph_q == '0) && (rph_q == '0);
  assign q_push_o   = accept && (sampled || frame_end_i);
  assign q_item_o   = '{raw: raw_i, col: col_q, row: row_q, sampled: sampled,
                        frame_end: frame_end_i};

  always_comb begin
    stride_eff = (stride_i == 8'd0) ? (STRIDE_BITS+1)'(1) : (STRIDE_BITS+1)'(stride_i);
    col_d = col_q;
    row_d = row_q;
    cph_d = cph_q;
    rph_d = rph_q;
    if (accept) begin
      if (frame_end_i) begin
        col_d = '0;
        row_d = '0;
        cph_d = '0;
        rph_d = '0;
      end else if (row_end_i) begin
        col_d = '0;
        cph_d = '0;
        if (row_q != '1) begin
          row_d = row_q + 1'b1;
        end
        rph_d = next_phase(rph_q, stride_eff);
      end else begin
        if (col_q != '1) begin
          col_d = col_q + 1'b1;
        end
        cph_d = next_phase(cph_q, stride_eff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/dpb_back.sv */
// Back part: decodes depth, checks bounds, projects x and y, keeps counters.
// Depends on dpb_pkg; drains dpb_queue and drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module dpb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpb_pkg::dpb_cfg_t  cfg_i,
  input  logic               q_empty_i,
  input  dpb_pkg::dpb_item_t q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dpb_pkg::dpb_flags_t out_flags_o,
  output logic [31:0]        out_x_o,
  output logic [31:0]        out_y_o,
  output logic [31:0]        out_z_o,
  output logic [31:0]        out_inv_o,
  output logic [31:0]        out_smp_o
);
  import dpb_pkg::*;

  back_state_e state_q, state_d;
  dpb_item_t   item_q;
  logic [31:0] zf_q, z_q;
  logic        fok_q, ok_q;
  logic [60:0] prod_q;
  logic [K_BITS-1:0]   kx_q, ky_q;
  logic [MAG_BITS-1:0] magx_q, magy_q;
  logic                negx_q, negy_q;
  logic [ACC_BITS-1:0] accx_q, accy_q, shx_q, shy_q;
  logic [5:0]          cnt_q;
  logic [31:0]         inv_cnt_q, smp_cnt_q;
  logic                ov_q;
  dpb_flags_t          of_q;
  logic [31:0]         ox_q, oy_q, oz_q, oinv_q, osmp_q;

  // Float decode of the queued item; millimetre value of the held item.
  logic [31:0] bits;
  logic [7:0]  ex, e, sh_up, sh_dn;
  logic [22:0] fr;
  logic [23:0] mant;
  logic [25:0] rtmp;
  logic [31:0] zf;
  logic        fok;
  logic [15:0] mm;

  always_comb begin
    bits  = (q_item_i.raw);
    if (cfg_i.fmt == FMT_F32_BE) begin
      bits = {q_item_i.raw[7:0], q_item_i.raw[15:8], q_item_i.raw[23:16],
              q_item_i.raw[31:24]};
    end
    ex    = bits[30:23];
    fr    = bits[22:0];
    mant  = (ex != 8'd0) ? {1'b1, fr} : {1'b0, fr};
    e     = (ex != 8'd0) ? ex : 8'd1;
    sh_up = e - 8'd134;
    sh_dn = 8'd134 - e;
    rtmp  = {2'b00, mant} + (26'd1 << (sh_dn - 8'd1));
    zf    = '0;
    fok   = 1'b1;
    if (ex == 8'hFF) begin
      fok = 1'b0;
    end else if (ex == 8'd0 && fr == '0) begin
      zf = '0;
    end else if (bits[31]) begin
      fok = 1'b0;
    end else if (e >= 8'd134) begin
      if (sh_up > 8'd8) begin
        fok = 1'b0;
      end else begin
        zf = {8'd0, mant} << sh_up;
      end
    end else if (sh_dn > 8'd25) begin
      zf = '0;
    end else begin
      zf = 32'(rtmp >> sh_dn);
    end
    mm = (cfg_i.fmt == FMT_MM_BE) ? {item_q.raw[7:0], item_q.raw[15:8]}
                                  : item_q.raw[15:0];
  end

  // Bound check and projection setup.
  logic [31:0] z;
  logic        zok;
  logic signed [MAG_BITS-1:0] dx, dy;

  always_comb begin
    z   = (cfg_i.fmt == FMT_MM_LE || cfg_i.fmt == FMT_MM_BE)
          ? 32'(prod_q[60:MM_SHIFT]) : zf_q;
    zok = fok_q && (z >= cfg_i.depth_lo) && (z <= cfg_i.depth_hi);
    dx  = $signed({2'b00, item_q.col, 16'd0}) - MAG_BITS'($signed(cfg_i.center_x));
    dy  = $signed({2'b00, item_q.row, 16'd0}) - MAG_BITS'($signed(cfg_i.center_y));
  end

  // Final rounding, range check and next counter values.
  logic [ACC_BITS-1:0] rax, ray;
  logic [50:0]         rx, ry;
  logic                ovfx, ovfy, pvalid;
  logic [31:0]         inv_n, smp_n;

  always_comb begin
    rax = accx_q + (ACC_BITS'(1) << (RND_POS - 1));
    ray = accy_q + (ACC_BITS'(1) << (RND_POS - 1));
    rx  = rax[ACC_BITS-1:RND_POS];
    ry  = ray[ACC_BITS-1:RND_POS];
    ovfx = negx_q ? (rx > 51'h80000000) : (rx > 51'h7FFFFFFF);
    ovfy = negy_q ? (ry > 51'h80000000) : (ry > 51'h7FFFFFFF);
    pvalid = item_q.sampled && ok_q && !ovfx && !ovfy;
    smp_n = smp_cnt_q;
    inv_n = inv_cnt_q;
    if (item_q.sampled) begin
      if (smp_n != '1) smp_n = smp_n + 1'b1;
      if (!pvalid && inv_n != '1) inv_n = inv_n + 1'b1;
    end
  end

  logic load_out;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = ST_DEC;
        end
      end
      ST_DEC:  state_d = item_q.sampled ? ST_BND : ST_FIN;
      ST_BND:  state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == MUL_STEPS - 6'd1) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      inv_cnt_q <= '0;
      smp_cnt_q <= '0;
      ov_q      <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        ov_q <= 1'b1;
        if (item_q.frame_end) begin
          inv_cnt_q <= '0;
          smp_cnt_q <= '0;
        end else begin
          inv_cnt_q <= inv_n;
          smp_cnt_q <= smp_n;
        end
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (state_q == ST_BND) begin
        cnt_q <= '0;
      end else if (state_q == ST_MUL) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
      zf_q   <= zf;
      fok_q  <= fok;
    end
    if (state_q == ST_DEC) begin
      prod_q <= 61'(({14'd0, mm} * 30'd8192) + MM_BIAS) * 61'(MM_RECIP);
      if (cfg_i.fmt == FMT_MM_LE || cfg_i.fmt == FMT_MM_BE) fok_q <= 1'b1;
      ok_q   <= 1'b0;
      accx_q <= '0;
      accy_q <= '0;
    end
    if (state_q == ST_BND) begin
      z_q    <= z;
      ok_q   <= zok;
      kx_q   <= cfg_i.inv_fx * z;
      ky_q   <= cfg_i.inv_fy * z;
      negx_q <= dx[MAG_BITS-1];
      negy_q <= dy[MAG_BITS-1];
      magx_q <= dx[MAG_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
      magy_q <= dy[MAG_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
    end
    if (state_q == ST_MUL) begin
      if (cnt_q == '0) begin
        accx_q <= magx_q[0] ? ACC_BITS'(kx_q) : '0;
        accy_q <= magy_q[0] ? ACC_BITS'(ky_q) : '0;
        shx_q  <= ACC_BITS'(kx_q) << 1;
        shy_q  <= ACC_BITS'(ky_q) << 1;
      end else begin
        if (magx_q[0]) accx_q <= accx_q + shx_q;
        if (magy_q[0]) accy_q <= accy_q + shy_q;
        shx_q <= shx_q << 1;
        shy_q <= shy_q << 1;
      end
      magx_q <= magx_q >> 1;
      magy_q <= magy_q >> 1;
    end
    if (load_out) begin
      of_q   <= '{sampled: item_q.sampled, point_valid: pvalid,
                  frame_done: item_q.frame_end};
      ox_q   <= pvalid ? (negx_q ? 32'd0 - rx[31:0] : rx[31:0]) : '0;
      oy_q   <= pvalid ? (negy_q ? 32'd0 - ry[31:0] : ry[31:0]) : '0;
      oz_q   <= pvalid ? z_q : '0;
      oinv_q <= inv_n;
      osmp_q <= smp_n;
    end
  end

  assign out_valid_o = ov_q;
  assign out_flags_o = of_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign out_inv_o   = oinv_q;
  assign out_smp_o   = osmp_q;

endmodule

`default_nettype wire

/* rtl/depth_pixel_backprojection.sv */
// Top level of the depth pixel back-projection block: configuration registers,
// front, queue and back. Depends on dpb_pkg, dpb_front, dpb_queue, dpb_back.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata raw_pixel, tuser row_end,
//                                                   tlast frame_end
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata points and totals,
//                                                   tuser flags, tlast frame_done
// cfg       in         cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// Pixels that give no result are not queued. A sampled pixel goes through the back part in
// order: pop, decode, bound check, 34 shift-add projection steps and output load.
// An unsampled frame-end pixel goes there from decode straight to output load.
// Two queued items let the front keep accepting while the back works.
// Reset clears positions and counters and loads the default configuration; no clearing pass is needed.
// The output register holds a result until it is taken, stalling the back part.
`timescale 1ns / 1ps
`default_nettype none

module depth_pixel_backprojection (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // raw_pixel
  input  logic [0:0]   s_axis_tuser,   // row_end
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // point_x, point_y, point_z, invalid_total, sampled_total
  output logic [159:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // sampled, point_valid
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);
  import dpb_pkg::*;

  dpb_cfg_t   cfg_q;
  dpb_item_t  push_item, pop_item;
  logic       q_push, q_pop, q_full, q_empty;
  dpb_flags_t flags;
  logic [31:0] px, py, pz, pinv, psmp, focal;

  assign focal = (cfg_wdata_i > 32'h80000000) ? 32'h80000000 : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{stride: 8'd1, fmt: FMT_MM_LE, depth_lo: 32'd6554,
                 depth_hi: 32'd655360, center_x: '0, center_y: '0,
                 inv_fx: '0, inv_fy: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STRIDE: cfg_q.stride    <= cfg_wdata_i[7:0];
        CFG_FORMAT: cfg_q.fmt       <= fmt_e'(cfg_wdata_i[1:0]);
        CFG_MIN:    cfg_q.depth_lo  <= cfg_wdata_i;
        CFG_MAX:    cfg_q.depth_hi  <= cfg_wdata_i;
        CFG_CX:     cfg_q.center_x  <= cfg_wdata_i;
        CFG_CY:     cfg_q.center_y  <= cfg_wdata_i;
        CFG_IFX:    cfg_q.inv_fx    <= focal;
        CFG_IFY:    cfg_q.inv_fy    <= focal;
        default: ;
      endcase
    end
  end

  dpb_front u_front (
    .clk_i, .rst_ni,
    .stride_i    (cfg_q.stride),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .raw_i       (s_axis_tdata),
    .row_end_i   (s_axis_tuser[0]),
    .frame_end_i (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  dpb_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  dpb_back u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_flags_o (flags),
    .out_x_o     (px),
    .out_y_o     (py),
    .out_z_o     (pz),
    .out_inv_o   (pinv),
    .out_smp_o   (psmp)
  );

  assign m_axis_tdata = {psmp, pinv, pz, py, px};
  assign m_axis_tuser = {flags.point_valid, flags.sampled};
  assign m_axis_tlast = flags.frame_done;

endmodule

`default_nettype wire

/* rtl/dpb_checker.sv */
// Port-level checks for depth_pixel_backprojection, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module dpb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_unsampled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && !m_axis_tuser[1])
    else $error("unsampled result without frame end or marked valid");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[95:0] == 96'd0)
    else $error("invalid point carries coordinates");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[159:128] != 32'd0 && m_axis_tdata[127:96] <= m_axis_tdata[159:128])
    else $error("running totals inconsistent");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
  .m_axis_tuser, .m_axis_tlast
);

`default_nettype wire
